// ===== rtl/arp_cache_and_responder_top_assert.svh =====
// ----------------------------------------------------------------------------
// ARP cache assertion macros
// Clocked assertion shorthands shared by the ARP cache RTL.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_AND_RESPONDER_TOP_ASSERT_SVH
`define ARP_CACHE_AND_RESPONDER_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ARPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP cache package
// Sizes, codes and shared types of the ARP cache and responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int PTR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int CNTO_W  = 10;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 64;

  localparam logic [IP_W-1:0]  BCAST_IP  = 32'hFFFF_FFFF;
  localparam logic [MAC_W-1:0] BCAST_MAC = {6{8'hFF}};
  localparam logic [15:0]      ARP_OP_REQUEST = 16'd1;

  typedef enum logic [1:0] {
    CMD_RX     = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_ADD    = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_OWN_IP  = 1'b0,
    REG_OWN_MAC = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_LOOKUP,
    OP_BCAST,
    OP_NONE
  } op_kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DONE
  } back_state_t;

  // Classified work item; for a store, ip/mac is also the reply destination.
  typedef struct packed {
    op_kind_t          kind;
    logic              reply;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  typedef struct packed {
    logic              reply_valid;
    logic [MAC_W-1:0]  reply_dest_mac;
    logic [IP_W-1:0]   reply_dest_ip;
    logic              lookup_hit;
    logic [MAC_W-1:0]  found_mac;
    logic [CNTO_W-1:0] entry_count;
  } result_t;

endpackage

// ===== rtl/arpc_if.sv =====
// ----------------------------------------------------------------------------
// ARP cache channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface arpc_in_if import arpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [15:0]        opcode;
  logic [MAC_W-1:0]   sender_mac;
  logic [IP_W-1:0]    sender_ip;
  logic [IP_W-1:0]    target_ip;
  logic [IP_W-1:0]    key_ip;
  logic [MAC_W-1:0]   entry_mac;

  modport source (output valid, cmd, opcode, sender_mac, sender_ip, target_ip,
                  key_ip, entry_mac, input ready);
  modport sink   (input valid, cmd, opcode, sender_mac, sender_ip, target_ip,
                  key_ip, entry_mac, output ready);
endinterface

interface arpc_out_if import arpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               reply_valid;
  logic [MAC_W-1:0]   reply_dest_mac;
  logic [IP_W-1:0]    reply_dest_ip;
  logic               lookup_hit;
  logic [MAC_W-1:0]   found_mac;
  logic [CNTO_W-1:0]  entry_count;

  modport source (output valid, reply_valid, reply_dest_mac, reply_dest_ip,
                  lookup_hit, found_mac, entry_count, input ready);
  modport sink   (input valid, reply_valid, reply_dest_mac, reply_dest_ip,
                  lookup_hit, found_mac, entry_count, output ready);
endinterface

// ===== rtl/arp_cache_and_responder_top.sv =====
// ----------------------------------------------------------------------------
// ARP cache and responder
// Ring table of IP-to-MAC pairs with lookup and request responder.
// ----------------------------------------------------------------------------
//  Port      Dir   Beat
//  in_ch     in    cmd, opcode, sender/target addresses, key, entry MAC
//  out_ch    out   reply flag and destination, lookup hit and MAC, count
//  cfg_*     in    APB writes/reads of own_ip (0x0) and own_mac (0x8)
//
//  Store, broadcast lookup and unused commands are handled in the engine's idle state.
//  A lookup scans the table through its single read port, one entry a cycle,
//  over up to fill_count entries, stopping at the first hit.
//  A two-beat queue lets the input side accept while the engine works.
//  No clearing pass after reset: entries below the fill count are the valid
//  ones. The result register holds a beat until the sink takes it.
// ----------------------------------------------------------------------------
module arp_cache_and_responder_top import arpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  arpc_in_if.sink           in_ch,
  arpc_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [IP_W-1:0]  own_ip_r, own_ip_nxt;
  logic [MAC_W-1:0] own_mac_r, own_mac_nxt;
  logic             cfg_wr;

  q_stat_t          q_stat;
  q_item_t          push_item, pop_item;
  logic             q_push, q_pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    own_ip_nxt  = own_ip_r;
    own_mac_nxt = own_mac_r;
    if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_paddr[3]))
        REG_OWN_IP:  own_ip_nxt  = cfg_pwdata[IP_W-1:0];
        REG_OWN_MAC: own_mac_nxt = cfg_pwdata[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(cfg_paddr[3]))
      REG_OWN_IP:  cfg_prdata = CFG_DW'(own_ip_r);
      REG_OWN_MAC: cfg_prdata = CFG_DW'(own_mac_r);
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
    end else begin
      own_ip_r  <= own_ip_nxt;
      own_mac_r <= own_mac_nxt;
    end
  end

  arpc_front u_front (
    .in_ch  (in_ch),
    .own_ip (own_ip_r),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_item (push_item)
  );

  arpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  arpc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_item (pop_item),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/arpc_front.sv =====
// ----------------------------------------------------------------------------
// ARP cache front end
// Accepts command beats, classifies them and pushes work items to the queue.
// ----------------------------------------------------------------------------
module arpc_front import arpc_pkg::*; (
  arpc_in_if.sink         in_ch,
  input  logic [IP_W-1:0] own_ip,
  input  q_stat_t         q_stat,
  output logic            q_push,
  output q_item_t         q_item
);

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && !q_stat.full;

  always_comb begin
    q_item.kind  = OP_NONE;
    q_item.reply = 1'b0;
    q_item.ip    = in_ch.key_ip;
    q_item.mac   = in_ch.entry_mac;
    unique case (in_ch.cmd)
      CMD_RX: begin
        q_item.kind  = OP_STORE;
        q_item.reply = (in_ch.opcode == ARP_OP_REQUEST) && (in_ch.target_ip == own_ip);
        q_item.ip    = in_ch.sender_ip;
        q_item.mac   = in_ch.sender_mac;
      end
      CMD_LOOKUP: begin
        // broadcast key is answered without touching the table
        q_item.kind = (in_ch.key_ip == BCAST_IP) ? OP_BCAST : OP_LOOKUP;
      end
      CMD_ADD: begin
        q_item.kind = OP_STORE;
      end
      default: begin
        q_item.kind = OP_NONE;
      end
    endcase
  end

endmodule

// ===== rtl/arpc_queue.sv =====
// ----------------------------------------------------------------------------
// ARP cache work queue
// Short FIFO between the front end and the table engine.
// ----------------------------------------------------------------------------
`include "arp_cache_and_responder_top_assert.svh"

module arpc_queue import arpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output q_item_t pop_item,
  output q_stat_t stat
);

  q_item_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_item   = q_mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= push_item;
    end
  end

  `ARPC_ASSERT(a_q_no_overflow, clk, rst_n, !(push && stat.full), "queue push while full")
  `ARPC_ASSERT(a_q_no_underflow, clk, rst_n, !(pop && stat.empty), "queue pop while empty")
  `ARPC_ASSERT(a_q_cnt_range, clk, rst_n, cnt_r <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

// ===== rtl/arpc_back.sv =====
// ----------------------------------------------------------------------------
// ARP cache table engine
// Stores pairs in the ring table, scans it for lookups, registers results.
// ----------------------------------------------------------------------------
`include "arp_cache_and_responder_top_assert.svh"

module arpc_back import arpc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  q_stat_t       q_stat,
  input  q_item_t       q_item,
  output logic          q_pop,
  arpc_out_if.source    out_ch
);

  back_state_t        state_r, state_nxt;
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   fill_inc;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [IP_W-1:0]    key_r, key_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               hit_r, hit_nxt;
  logic [MAC_W-1:0]   fmac_r, fmac_nxt;
  logic               out_vld_r, out_vld_nxt;
  result_t            out_r, out_nxt;

  // table memory, one port each for write and read
  entry_t             tbl_mem [TABLE_DEPTH];
  entry_t             rd_data_r;
  logic               wr_en, rd_en;
  logic [PTR_W-1:0]   rd_addr;

  logic               res_free;
  logic               scan_hit;
  logic               scan_more;

  assign res_free  = !out_vld_r || out_ch.ready;
  assign scan_hit  = rd_vld_r && (rd_data_r.ip == key_r);
  assign scan_more = idx_r < fill_r;
  // entries below the fill count are exactly the ones ever written
  assign fill_inc  = (fill_r < CNT_W'(TABLE_DEPTH)) ? fill_r + 1'b1 : fill_r;
  assign rd_addr   = idx_r[PTR_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty && q_item.kind == OP_LOOKUP) begin
          state_nxt = B_SCAN;
        end
      end
      B_SCAN: begin
        if (scan_hit || !scan_more) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (res_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_vld_nxt  = 1'b0;
    wptr_nxt    = wptr_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    hit_nxt     = hit_r;
    fmac_nxt    = fmac_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    out_nxt     = out_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          if (q_item.kind == OP_LOOKUP) begin
            q_pop   = 1'b1;
            key_nxt = q_item.ip;
            idx_nxt = '0;
          end else if (res_free) begin
            q_pop       = 1'b1;
            out_vld_nxt = 1'b1;
            out_nxt     = '0;
            out_nxt.entry_count = CNTO_W'(fill_r);
            unique case (q_item.kind)
              OP_STORE: begin
                wr_en    = 1'b1;
                fill_nxt = fill_inc;
                wptr_nxt = (wptr_r == PTR_W'(TABLE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
                out_nxt.entry_count = CNTO_W'(fill_inc);
                if (q_item.reply) begin
                  out_nxt.reply_valid    = 1'b1;
                  out_nxt.reply_dest_mac = q_item.mac;
                  out_nxt.reply_dest_ip  = q_item.ip;
                end
              end
              OP_BCAST: begin
                out_nxt.lookup_hit = 1'b1;
                out_nxt.found_mac  = BCAST_MAC;
              end
              default: ;
            endcase
          end
        end
      end
      B_SCAN: begin
        // read issued for idx, compared in the cycle after
        if (scan_hit) begin
          hit_nxt  = 1'b1;
          fmac_nxt = rd_data_r.mac;
        end else if (scan_more) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + 1'b1;
        end else begin
          hit_nxt  = 1'b0;
          fmac_nxt = '0;
        end
      end
      B_DONE: begin
        if (res_free) begin
          out_vld_nxt         = 1'b1;
          out_nxt             = '0;
          out_nxt.lookup_hit  = hit_r;
          out_nxt.found_mac   = fmac_r;
          out_nxt.entry_count = CNTO_W'(fill_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      wptr_r    <= '0;
      fill_r    <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wptr_r    <= wptr_nxt;
      fill_r    <= fill_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    key_r  <= key_nxt;
    hit_r  <= hit_nxt;
    fmac_r <= fmac_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wptr_r] <= '{ip: q_item.ip, mac: q_item.mac};
    end
    if (rd_en) begin
      rd_data_r <= tbl_mem[rd_addr];
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.reply_valid    = out_r.reply_valid;
  assign out_ch.reply_dest_mac = out_r.reply_dest_mac;
  assign out_ch.reply_dest_ip  = out_r.reply_dest_ip;
  assign out_ch.lookup_hit     = out_r.lookup_hit;
  assign out_ch.found_mac      = out_r.found_mac;
  assign out_ch.entry_count    = out_r.entry_count;

  `ARPC_ASSERT(a_fill_range, clk, rst_n, fill_r <= CNT_W'(TABLE_DEPTH), "fill count above depth")
  `ARPC_ASSERT(a_ptr_tracks_fill, clk, rst_n,
    (fill_r == CNT_W'(TABLE_DEPTH)) || (CNT_W'(wptr_r) == fill_r),
    "write pointer differs from fill count before wrap")
  `ARPC_ASSERT(a_scan_bound, clk, rst_n, (state_r != B_SCAN) || (idx_r <= fill_r),
    "scan index past filled entries")
  `ARPC_ASSERT_NEXT(a_scan_no_write, clk, rst_n, state_r == B_SCAN,
    fill_r == $past(fill_r), "table written during a scan")

endmodule
